>>> hw/rtl/jkse_pkg.sv
// ----------------------------------------------------------------------------
// jkse_pkg
// Types and constants shared by the JSON key string extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package jkse_pkg;

  // key and match window sizes
  localparam int unsigned KeyMax      = 32;
  localparam int unsigned WinDepth    = KeyMax + 2;
  localparam int unsigned KeyLenWidth = 6;
  localparam int unsigned FillWidth   = $clog2(WinDepth + 1);
  localparam int unsigned KeyRegs     = KeyMax / 8;

  // result queue, room for the two results one item can cause
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  // characters
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY_LEN   = 3'd0,
    CFG_KEY_0_7   = 3'd1,
    CFG_KEY_8_15  = 3'd2,
    CFG_KEY_16_23 = 3'd3,
    CFG_KEY_24_31 = 3'd4
  } cfg_idx_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_MISS = 2'd2
  } kind_e;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_SEARCH      = 6'b000001,
    PH_AFTER_KEY   = 6'b000010,
    PH_AFTER_COLON = 6'b000100,
    PH_VALUE       = 6'b001000,
    PH_ESCAPE      = 6'b010000,
    PH_DONE        = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

  // json whitespace
  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/json_key_string_extractor_core.sv
// ----------------------------------------------------------------------------
// json_key_string_extractor_core
// Finds a quoted key in a JSON body and emits its unescaped string value.
// ----------------------------------------------------------------------------
// The body enters one byte per item on the body channel (valid/ready), with
// body_last_i on the final byte. The key length and key bytes are written on
// the plain configuration port while the block is idle.
// Each item causes zero, one or two results on the result channel
// (valid/ready): value bytes, then value complete, or key not found.
// An accepted item is held in the input register; the phase, window
// compare and result decode run on it there, and the results land in a
// four-entry result queue, from which the result channel reads.
// One item per cycle is sustained while the result queue has room for two
// results; the rate is set by the combinational compare of the 34-byte
// match window against the quoted key. An item that causes two results
// needs two reads on the result side. A stalled receiver fills the queue
// and then holds body_ready_o low once the input register holds an item.
// Reset clears the phase to key search, empties the window and the queue,
// and sets the key length to one and the key bytes to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module json_key_string_extractor_core
  import jkse_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // body channel
  input  wire logic        body_valid_i,
  output logic             body_ready_o,
  input  wire logic [7:0]  body_byte_i,
  input  wire logic        body_last_i,
  // result channel
  output logic             result_valid_o,
  input  wire logic        result_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       value_byte_o
);

  // configuration registers
  logic [KeyLenWidth-1:0] key_len_q;
  logic [63:0]            key_q [KeyRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KeyLenWidth'(1);
      for (int r = 0; r < KeyRegs; r++) key_q[r] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY_LEN:   key_len_q <= cfg_data_i[KeyLenWidth-1:0];
        CFG_KEY_0_7:   key_q[0]  <= cfg_data_i;
        CFG_KEY_8_15:  key_q[1]  <= cfg_data_i;
        CFG_KEY_16_23: key_q[2]  <= cfg_data_i;
        CFG_KEY_24_31: key_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result queue state
  result_t               fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  fifo_room;
  logic                  pop;

  assign fifo_room = cnt_q <= FifoCntW'(FifoDepth - 2);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       stg_fire;

  assign stg_fire     = in_vld_q && fifo_room;
  assign body_ready_o = !in_vld_q || stg_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (body_ready_o) begin
      in_vld_q <= body_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (body_ready_o && body_valid_i) begin
      in_byte_q <= body_byte_i;
      in_last_q <= body_last_i;
    end
  end

  // parser state
  phase_e               phase_q, phase_d;
  logic [FillWidth-1:0] fill_q, fill_d, fill_inc;
  logic [7:0]           win_q   [WinDepth];
  logic [7:0]           win_new [WinDepth];
  logic                 shift_en;

  // window as it stands with the current byte shifted in
  always_comb begin
    win_new[0] = in_byte_q;
    for (int k = 1; k < WinDepth; k++) win_new[k] = win_q[k-1];
  end

  assign fill_inc = (fill_q < FillWidth'(WinDepth)) ? fill_q + FillWidth'(1) : fill_q;

  // compare every window position with the quoted key
  logic [KeyLenWidth-1:0] klen;
  logic [WinDepth-1:0]    pos_ok;
  logic                   hit;

  assign klen = (key_len_q > KeyLenWidth'(KeyMax)) ? KeyLenWidth'(KeyMax) : key_len_q;

  always_comb begin
    logic [KeyLenWidth-1:0] kk;
    logic [KeyLenWidth-1:0] idx;
    logic [7:0]             kbyte;
    kk    = '0;
    idx   = '0;
    kbyte = '0;
    for (int k = 0; k < WinDepth; k++) begin
      kk    = KeyLenWidth'(k);
      idx   = klen - kk;
      kbyte = key_q[idx[4:3]][idx[2:0]*8 +: 8];
      if (kk == '0 || kk == klen + KeyLenWidth'(1)) begin
        pos_ok[k] = win_new[k] == ChQuote;
      end else if (kk <= klen) begin
        pos_ok[k] = win_new[k] == kbyte;
      end else begin
        pos_ok[k] = 1'b1;
      end
    end
  end

  assign hit = (&pos_ok) && (fill_inc >= FillWidth'(klen) + FillWidth'(2));

  // phase update and result decode
  logic    res_v0, res_v1;
  result_t res0, res1;
  logic    ws;

  assign ws = is_ws(in_byte_q);

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    shift_en = 1'b0;
    res_v0   = 1'b0;
    res_v1   = 1'b0;
    res0     = '{kind: KIND_MISS, data: 8'h00};
    res1     = '{kind: KIND_DONE, data: 8'h00};
    case (phase_q)
      PH_SEARCH: begin
        shift_en = 1'b1;
        if (hit) begin
          fill_d  = '0;
          phase_d = PH_AFTER_KEY;
        end else begin
          fill_d = fill_inc;
        end
        res_v0 = in_last_q;
      end
      PH_AFTER_KEY: begin
        if (in_byte_q == ChColon) begin
          phase_d = PH_AFTER_COLON;
        end else if (!ws) begin
          // window restarts with this byte; one byte can never hold a match
          shift_en = 1'b1;
          fill_d   = FillWidth'(1);
          phase_d  = PH_SEARCH;
        end
        res_v0 = in_last_q;
      end
      PH_AFTER_COLON: begin
        if (in_byte_q == ChQuote) begin
          phase_d = PH_VALUE;
          res_v0  = in_last_q;
          res0    = '{kind: KIND_DONE, data: 8'h00};
        end else if (!ws) begin
          phase_d = PH_DONE;
          res_v0  = 1'b1;
        end else begin
          res_v0 = in_last_q;
        end
      end
      PH_VALUE: begin
        if (in_byte_q == ChQuote) begin
          phase_d = PH_DONE;
          res_v0  = 1'b1;
          res0    = '{kind: KIND_DONE, data: 8'h00};
        end else if (in_byte_q == ChBslash && !in_last_q) begin
          phase_d = PH_ESCAPE;
        end else begin
          res_v0 = 1'b1;
          res0   = '{kind: KIND_BYTE, data: in_byte_q};
          res_v1 = in_last_q;
        end
      end
      PH_ESCAPE: begin
        phase_d = PH_VALUE;
        res_v0  = 1'b1;
        if (in_byte_q == ChN) begin
          res0 = '{kind: KIND_BYTE, data: ChLf};
        end else if (in_byte_q == ChT) begin
          res0 = '{kind: KIND_BYTE, data: ChTab};
        end else begin
          res0 = '{kind: KIND_BYTE, data: in_byte_q};
        end
        res_v1 = in_last_q;
      end
      PH_DONE: ;
      default: ;
    endcase
    // end of body starts a fresh search
    if (in_last_q) begin
      phase_d = PH_SEARCH;
      fill_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      fill_q  <= '0;
    end else if (stg_fire) begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
    end
  end

  // match window shift line
  always_ff @(posedge clk_i) begin
    if (stg_fire && shift_en) begin
      for (int k = 0; k < WinDepth; k++) win_q[k] <= win_new[k];
    end
  end

  // result queue, up to two writes and one read per cycle
  logic                push0, push1;
  logic [FifoPtrW-1:0] wr_ptr_p1;

  assign push0     = stg_fire && res_v0;
  assign push1     = stg_fire && res_v1;
  assign wr_ptr_p1 = wr_ptr_q + FifoPtrW'(1);
  assign pop       = result_valid_o && result_ready_i;

  assign cnt_d = cnt_q + FifoCntW'(push0) + FifoCntW'(push1) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(push0) + FifoPtrW'(push1);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) fifo_q[wr_ptr_q]  <= res0;
    if (push1) fifo_q[wr_ptr_p1] <= res1;
  end

  // result outputs
  assign result_valid_o = cnt_q != '0;
  assign result_kind_o  = fifo_q[rd_ptr_q].kind;
  assign value_byte_o   = fifo_q[rd_ptr_q].data;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parse phase not one-hot");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_fire && in_last_q |=> phase_q == PH_SEARCH && fill_q == '0)
    else $error("end of body did not restart the search");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o != KIND_BYTE |-> value_byte_o == 8'h00)
    else $error("non-byte result carries data");

  a_second_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1 |-> push0 && res0.kind == KIND_BYTE && in_last_q)
    else $error("second result without a value byte on the final byte");

endmodule

`default_nettype wire
